FILE: hw/rtl/booth_multiply_add_unit_assert.svh
// Assertion macros shared by the booth multiply-add unit RTL.
`ifndef BOOTH_MULTIPLY_ADD_UNIT_ASSERT_SVH
`define BOOTH_MULTIPLY_ADD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BMAU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmau assertion failed");
// Next-cycle implication, disabled during reset.
`define BMAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmau assertion failed");
`else
`define BMAU_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BMAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/bmau_pkg.sv
// Shared types and constants of the booth multiply-add unit.
package bmau_pkg;

   localparam int unsigned DATA_WIDTH            = 32;
   localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_MUL = 1'b1;

   // Booth recoding of {multiplier bit, previous bit}.
   localparam logic [1:0] BOOTH_SUB = 2'b10;
   localparam logic [1:0] BOOTH_ADD = 2'b01;

   typedef struct packed {
      logic valid;
      logic func;
      logic prev;
   } bmau_ctl_type;

endpackage

FILE: hw/rtl/bmau_channels.sv
// Request and response channel interfaces of the booth multiply-add unit.
interface bmau_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic signed [bmau_pkg::DATA_WIDTH-1:0] operand_a;
   logic signed [bmau_pkg::DATA_WIDTH-1:0] operand_b;

   modport source (output valid, output func, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input func, input operand_a, input operand_b,
                   output ready);
endinterface

interface bmau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bmau_pkg::DATA_WIDTH-1:0] result_low;
   logic [bmau_pkg::DATA_WIDTH-1:0] result_high;

   modport source (output valid, output result_low, output result_high, input ready);
   modport sink   (input valid, input result_low, input result_high, output ready);
endinterface

FILE: hw/rtl/booth_multiply_add_unit.sv
// Top level of the pipelined add / signed Booth multiply unit.
// The unit takes request words on req_ch (func, operand_a, operand_b) and
// returns one response word per request on rsp_ch (result_low, result_high),
// in request order. Func selects a wrapping add, whose high half is zero, or
// a signed multiply whose full double-width product is split into halves.
// Only the low OPERAND_WIDTH bits of each operand are used.
// The pipeline is an entry stage, one stage per Booth step (OPERAND_WIDTH of
// them, one add or subtract and shift each) and an output register, and a
// response passes through each of them in turn. One word is accepted every
// cycle unless the receiver stalls while every stage holds a word.
// Every stage has its own valid bit and accepts a new word whenever it is
// empty or its successor takes its word, so bubbles close up while the
// receiver stalls; a held response keeps its value until it is taken.
// The synchronous reset clears all valid bits; payload registers keep
// whatever they held and are ignored until refilled.
`include "booth_multiply_add_unit_assert.svh"

module booth_multiply_add_unit #(
   parameter int unsigned OPERAND_WIDTH = bmau_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bmau_req_if.sink    req_ch,
   bmau_rsp_if.source  rsp_ch
);

   localparam int unsigned ACC_WIDTH = OPERAND_WIDTH + 2;
   localparam int unsigned STEPS     = OPERAND_WIDTH;

   // Index k carries the output of stage k; stage 0 is the entry stage.
   bmau_pkg::bmau_ctl_type       stage_ctl   [0:STEPS];
   logic signed [ACC_WIDTH-1:0]  stage_acc   [0:STEPS];
   logic [OPERAND_WIDTH-1:0]     stage_q     [0:STEPS];
   logic [OPERAND_WIDTH-1:0]     stage_mcand [0:STEPS];
   logic                         stage_ready [0:STEPS];

   bmau_entry #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_entry (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_ctl   (stage_ctl[0]),
      .out_acc   (stage_acc[0]),
      .out_q     (stage_q[0]),
      .out_mcand (stage_mcand[0]),
      .out_ready (stage_ready[0])
   );

   // Each Booth stage reports upstream whether it can take a word.
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      bmau_step #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (stage_ctl[k-1]),
         .in_acc    (stage_acc[k-1]),
         .in_q      (stage_q[k-1]),
         .in_mcand  (stage_mcand[k-1]),
         .in_ready  (stage_ready[k-1]),
         .out_ctl   (stage_ctl[k]),
         .out_acc   (stage_acc[k]),
         .out_q     (stage_q[k]),
         .out_mcand (stage_mcand[k]),
         .out_ready (stage_ready[k])
      );
   end

   bmau_out #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_out (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (stage_ctl[STEPS]),
      .in_acc   (stage_acc[STEPS]),
      .in_q     (stage_q[STEPS]),
      .in_ready (stage_ready[STEPS]),
      .rsp_ch   (rsp_ch)
   );

   // An empty entry stage must always be able to take a request.
   `BMAU_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !stage_ctl[0].valid,
      req_ch.ready)

endmodule

FILE: hw/rtl/bmau_entry.sv
// Entry stage: captures a request word, forms the sum and seeds the Booth state.
module bmau_entry #(
   parameter int unsigned OPERAND_WIDTH = bmau_pkg::OPERAND_WIDTH_DEFAULT,
   localparam int unsigned ACC_WIDTH = OPERAND_WIDTH + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   bmau_req_if.sink                     req_ch,
   output bmau_pkg::bmau_ctl_type       out_ctl,
   output logic signed [ACC_WIDTH-1:0]  out_acc,
   output logic [OPERAND_WIDTH-1:0]     out_q,
   output logic [OPERAND_WIDTH-1:0]     out_mcand,
   input  logic                         out_ready
);

   bmau_pkg::bmau_ctl_type       ctl_ff, ctl_in;
   logic [OPERAND_WIDTH-1:0]     q_ff, q_in;
   logic [OPERAND_WIDTH-1:0]     mcand_ff;
   logic                         take;

   assign req_ch.ready = !ctl_ff.valid || out_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      ctl_in.valid = req_ch.valid;
      ctl_in.func  = req_ch.func;
      ctl_in.prev  = 1'b0;
      // An add leaves its sum in the multiplier register; the Booth stages pass it on.
      if (req_ch.func == bmau_pkg::FUNC_ADD) begin
         q_in = req_ch.operand_a[OPERAND_WIDTH-1:0] + req_ch.operand_b[OPERAND_WIDTH-1:0];
      end else begin
         q_in = req_ch.operand_b[OPERAND_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (req_ch.ready) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff     <= q_in;
         mcand_ff <= req_ch.operand_a[OPERAND_WIDTH-1:0];
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_acc   = '0;
   assign out_q     = q_ff;
   assign out_mcand = mcand_ff;

endmodule

FILE: hw/rtl/bmau_step.sv
// One radix-2 Booth step: conditional add or subtract, then arithmetic right shift.
`include "booth_multiply_add_unit_assert.svh"

module bmau_step #(
   parameter int unsigned OPERAND_WIDTH = bmau_pkg::OPERAND_WIDTH_DEFAULT,
   localparam int unsigned ACC_WIDTH = OPERAND_WIDTH + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bmau_pkg::bmau_ctl_type       in_ctl,
   input  logic signed [ACC_WIDTH-1:0]  in_acc,
   input  logic [OPERAND_WIDTH-1:0]     in_q,
   input  logic [OPERAND_WIDTH-1:0]     in_mcand,
   output logic                         in_ready,
   output bmau_pkg::bmau_ctl_type       out_ctl,
   output logic signed [ACC_WIDTH-1:0]  out_acc,
   output logic [OPERAND_WIDTH-1:0]     out_q,
   output logic [OPERAND_WIDTH-1:0]     out_mcand,
   input  logic                         out_ready
);

   bmau_pkg::bmau_ctl_type       ctl_ff, ctl_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in, acc_sum, mcand_ext;
   logic [OPERAND_WIDTH-1:0]     q_ff, q_in;
   logic [OPERAND_WIDTH-1:0]     mcand_ff;

   assign in_ready  = !ctl_ff.valid || out_ready;
   assign mcand_ext = $signed({{2{in_mcand[OPERAND_WIDTH-1]}}, in_mcand});

   always_comb begin
      case ({in_q[0], in_ctl.prev})
         bmau_pkg::BOOTH_SUB: acc_sum = in_acc - mcand_ext;
         bmau_pkg::BOOTH_ADD: acc_sum = in_acc + mcand_ext;
         default:             acc_sum = in_acc;
      endcase
      ctl_in = in_ctl;
      if (in_ctl.func == bmau_pkg::FUNC_MUL) begin
         ctl_in.prev = in_q[0];
         q_in        = {acc_sum[0], in_q[OPERAND_WIDTH-1:1]};
         acc_in      = {acc_sum[ACC_WIDTH-1], acc_sum[ACC_WIDTH-1:1]};
      end else begin
         q_in        = in_q;
         acc_in      = in_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (in_ready) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         acc_ff   <= acc_in;
         q_ff     <= q_in;
         mcand_ff <= in_mcand;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_acc   = acc_ff;
   assign out_q     = q_ff;
   assign out_mcand = mcand_ff;

   `BMAU_ASSERT_NEXT(a_step_hold, clock, reset, ctl_ff.valid && !out_ready,
      ctl_ff.valid && $stable(acc_ff) && $stable(q_ff))
   `BMAU_ASSERT_IMPLIES(a_add_acc_zero, clock, reset,
      ctl_ff.valid && ctl_ff.func == bmau_pkg::FUNC_ADD, acc_ff == '0)

endmodule

FILE: hw/rtl/bmau_out.sv
// Output stage: formats the final Booth state into a response word and holds it.
module bmau_out #(
   parameter int unsigned OPERAND_WIDTH = bmau_pkg::OPERAND_WIDTH_DEFAULT,
   localparam int unsigned ACC_WIDTH = OPERAND_WIDTH + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bmau_pkg::bmau_ctl_type       in_ctl,
   input  logic signed [ACC_WIDTH-1:0]  in_acc,
   input  logic [OPERAND_WIDTH-1:0]     in_q,
   output logic                         in_ready,
   bmau_rsp_if.source                   rsp_ch
);

   logic                            valid_ff;
   logic [bmau_pkg::DATA_WIDTH-1:0] low_ff, low_in, high_ff, high_in;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      low_in                     = '0;
      low_in[OPERAND_WIDTH-1:0]  = in_q;
      high_in                    = '0;
      if (in_ctl.func == bmau_pkg::FUNC_MUL) begin
         high_in[OPERAND_WIDTH-1:0] = in_acc[OPERAND_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid) begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.result_low  = low_ff;
   assign rsp_ch.result_high = high_ff;

endmodule

FILE: dv/booth_multiply_add_unit_test.sv
// Self-checking testbench of the booth multiply-add unit: directed corners, then random words.
module booth_multiply_add_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WIDTH = bmau_pkg::DATA_WIDTH;

   localparam logic FUNC_ADD = bmau_pkg::FUNC_ADD;
   localparam logic FUNC_MUL = bmau_pkg::FUNC_MUL;

   // Operand corners in two's complement.
   localparam logic [WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MOST_POSITIVE = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] ALL_ONES      = {WIDTH{1'b1}};
   localparam logic [WIDTH-1:0] ZERO          = '0;
   localparam logic [WIDTH-1:0] ONE           = {{(WIDTH-1){1'b0}}, 1'b1};
   localparam logic [WIDTH-1:0] ALT_HIGH      = 32'hAAAA_AAAA;
   localparam logic [WIDTH-1:0] ALT_LOW       = 32'h5555_5555;

   // The drain at the end waits longer than a response takes to cross the pipeline.
   localparam int unsigned PIPE_LATENCY   = WIDTH + 1;
   localparam int unsigned DRAIN_CYCLES   = PIPE_LATENCY + 16;
   // Cycles in which no word moves on either channel before the run is declared
   // hung.  A correct run never comes near this, even at the heaviest stall rates.
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned RANDOM_WORDS   = 1500;
   localparam int unsigned PHASE_COUNT    = 4;

   typedef struct packed {
      logic [WIDTH-1:0] result_low;
      logic [WIDTH-1:0] result_high;
   } result_word_type;

   // Holds the results that the accepted requests must produce, in order, and
   // checks every response word against the oldest one.
   class result_ledger;
      result_word_type pending_results[$];
      int unsigned     add_count;
      int unsigned     mul_count;
      int unsigned     checked_count;
      int unsigned     error_count;

      // Work out the sum or the full signed product of one request word.
      function result_word_type compute_result(logic func, logic signed [WIDTH-1:0] a,
                                               logic signed [WIDTH-1:0] b);
         result_word_type      word;
         logic signed [63:0]   wide_a;
         logic signed [63:0]   wide_b;
         logic signed [63:0]   product;
         wide_a = a;
         wide_b = b;
         if (func == FUNC_ADD) begin
            word.result_low  = a + b;
            word.result_high = '0;
         end else begin
            // Booth recoding with guard bits yields the exact signed product,
            // even for the most negative multiplicand.
            product          = wide_a * wide_b;
            word.result_low  = product[WIDTH-1:0];
            word.result_high = product[2*WIDTH-1:WIDTH];
         end
         return word;
      endfunction

      function void note_request(logic func, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
         pending_results.push_back(compute_result(func, a, b));
         if (func == FUNC_ADD)
            add_count++;
         else
            mul_count++;
      endfunction

      function void check_response(logic [WIDTH-1:0] low, logic [WIDTH-1:0] high);
         result_word_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: response word with nothing expected: low %h high %h",
                     $time, low, high);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         if (low !== want.result_low) begin
            $display("%0t: result_low mismatch: expected %h, actual %h",
                     $time, want.result_low, low);
            error_count++;
         end
         if (high !== want.result_high) begin
            $display("%0t: result_high mismatch: expected %h, actual %h",
                     $time, want.result_high, high);
            error_count++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   bmau_req_if req_ch();
   bmau_rsp_if rsp_ch();

   booth_multiply_add_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   result_ledger ledger = new();

   // Idle rates of the current phase, in percent of cycles.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // The receiver decides once per cycle whether it takes a response word.
   // At zero percent it never stalls, which gives long stretches of full rate.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Both handshakes are sampled at the edge, before any update of that edge
   // lands, so the order of processes within the time step does not matter.
   // The watchdog counts edges at which neither channel moves a word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            ledger.note_request(req_ch.func, req_ch.operand_a, req_ch.operand_b);
         if (rsp_ch.valid && rsp_ch.ready)
            ledger.check_response(rsp_ch.result_low, rsp_ch.result_high);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no word moved for %0d cycles, %0d results still expected",
                        $time, quiet_cycles, ledger.outstanding());
               $display("booth_multiply_add_unit regression: fail");
               $finish;
            end
         end
      end
   end

   // Offers one request word and returns at the edge that accepts it.  The
   // sender may first sit idle for a random number of cycles; valid is only
   // assigned once per edge, so back-to-back words keep valid high.
   task automatic send_word(input logic func, input logic [WIDTH-1:0] a,
                            input logic [WIDTH-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.func      <= 1'($urandom_range(0, 1));
         req_ch.operand_a <= $urandom;
         req_ch.operand_b <= $urandom;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drops valid and holds off until every expected result has come back.
   // The first wait lets the monitor note the word accepted at this edge.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (ledger.outstanding() != 0);
   endtask

   // Random operands lean on the corners that matter to Booth recoding: the
   // extremes, zero, minus one, short values and long runs of equal bits.
   function automatic logic [WIDTH-1:0] pick_operand();
      logic [WIDTH-1:0] value;
      case ($urandom_range(0, 11))
         0:       value = MOST_NEGATIVE;
         1:       value = MOST_POSITIVE;
         2:       value = ZERO;
         3:       value = ALL_ONES;
         4:       value = ONE;
         5:       value = $urandom_range(0, 255) - 128;
         6:       value = ALL_ONES << $urandom_range(0, WIDTH - 1);
         7:       value = ALL_ONES >> $urandom_range(0, WIDTH - 1);
         default: value = $urandom;
      endcase
      return value;
   endfunction

   initial begin
      int unsigned phase_sender[PHASE_COUNT];
      int unsigned phase_receiver[PHASE_COUNT];

      phase_sender     = '{0, 60, 0, 36};
      phase_receiver   = '{0, 0, 60, 36};
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.func      = FUNC_ADD;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready     = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words at full rate: both operations on the operand extremes,
      // add overflow in both directions, and the most negative multiplicand.
      send_word(FUNC_ADD, ZERO,          ZERO);
      send_word(FUNC_ADD, MOST_POSITIVE, ONE);
      send_word(FUNC_ADD, MOST_NEGATIVE, MOST_NEGATIVE);
      send_word(FUNC_ADD, MOST_NEGATIVE, ALL_ONES);
      send_word(FUNC_ADD, ALL_ONES,      ONE);
      send_word(FUNC_ADD, ALL_ONES,      ALL_ONES);
      send_word(FUNC_ADD, ALT_HIGH,      ALT_LOW);
      send_word(FUNC_ADD, MOST_POSITIVE, MOST_POSITIVE);
      send_word(FUNC_MUL, ZERO,          MOST_NEGATIVE);
      send_word(FUNC_MUL, MOST_NEGATIVE, ZERO);
      send_word(FUNC_MUL, ONE,           ONE);
      send_word(FUNC_MUL, ALL_ONES,      ALL_ONES);
      send_word(FUNC_MUL, MOST_NEGATIVE, MOST_NEGATIVE);
      send_word(FUNC_MUL, MOST_NEGATIVE, ALL_ONES);
      send_word(FUNC_MUL, MOST_NEGATIVE, ONE);
      send_word(FUNC_MUL, MOST_NEGATIVE, MOST_POSITIVE);
      send_word(FUNC_MUL, MOST_POSITIVE, MOST_POSITIVE);
      send_word(FUNC_MUL, MOST_POSITIVE, MOST_NEGATIVE);
      send_word(FUNC_MUL, ALT_HIGH,      ALT_LOW);
      send_word(FUNC_MUL, ALT_LOW,       ALT_HIGH);
      send_word(FUNC_MUL, ALL_ONES,      MOST_POSITIVE);
      send_word(FUNC_MUL, 32'h0001_0000, 32'h0001_0000);

      // The sender stops until the pipeline has drained completely.
      wait_for_results();

      // Random words in phases of different sender idle and receiver stall rates;
      // each phase ends with the pipeline drained, so every phase starts from an empty unit.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct  = phase_sender[phase];
         recv_stall_pct = phase_receiver[phase];
         for (int unsigned n = 0; n < RANDOM_WORDS / PHASE_COUNT; n++)
            send_word(1'($urandom_range(0, 1)), pick_operand(), pick_operand());
         wait_for_results();
      end

      recv_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response words from %0d adds and %0d multiplies,",
               ledger.checked_count, ledger.add_count, ledger.mul_count);
      $display("across %0d idle and stall phases; %0d errors found.",
               PHASE_COUNT, ledger.error_count);
      if (ledger.error_count == 0 && ledger.outstanding() == 0)
         $display("booth_multiply_add_unit regression: pass");
      else
         $display("booth_multiply_add_unit regression: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bmau_pkg.sv
hw/rtl/bmau_channels.sv
hw/rtl/bmau_entry.sv
hw/rtl/bmau_step.sv
hw/rtl/bmau_out.sv
hw/rtl/booth_multiply_add_unit.sv
dv/booth_multiply_add_unit_test.sv
